// File: hdl/rppd_pkg.sv
// ----------------------------------------------------------------------------
// rppd_pkg
// Shared types, mode table and colour helpers of the planar palette decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rppd_pkg;

   localparam int PALETTE_DEPTH = 16384;
   localparam int MAX_WIDTH     = 416;
   localparam int ADDR_W        = $clog2(PALETTE_DEPTH);
   localparam int RECIP_SHIFT   = 20;
   localparam int RECIP_W       = 15;
   localparam int Q_W           = ADDR_W + RECIP_W - RECIP_SHIFT;

   localparam logic [1:0] CSR_MODE_SELECT = 2'd0;
   localparam logic [1:0] CSR_STE_BIT     = 2'd1;
   localparam logic [1:0] CSR_EXTRA_BIT   = 2'd2;

   typedef struct packed {
      logic [5:0]         ncol;
      logic [2:0]         nfix;
      logic               border;
      logic [9:0]         start;
      logic [8:0]         wid;
      logic [8:0]         hgt;
      logic [5:0]         stride;
      logic [13:0]        psize;
      logic [5:0]         edge_pos;
      logic [RECIP_W-1:0] recip;
   } mode_type;

   typedef struct packed {
      logic accept;
      logic pal_begin;
      logic mod_q;
      logic pal_entry;
      logic img_shift;
      logic pix_init;
      logic ld_addr;
      logic ld_write;
      logic chg_write;
      logic pix_out;
   } cmd_type;

   typedef struct packed {
      logic in_palette;
      logic pal_active;
      logic img_done;
      logic group_end;
      logic pal_take;
      logic pal_last;
      logic col_zero;
      logic chg_hit;
      logic ld_last;
      logic out_busy;
      logic pix_stop;
   } status_type;

   function automatic mode_type mode_info(input logic [1:0] md);
      mode_type m;
      case (md)
         2'd0: m = '{6'd54, 3'd0, 1'b1, 10'd33, 9'd320, 9'd199, 6'd54, 14'd10746,
                     6'd48, 15'd19419};
         2'd1: m = '{6'd48, 3'd0, 1'b1, 10'd9, 9'd320, 9'd199, 6'd48, 14'd9552,
                     6'd32, 15'd21846};
         2'd2: m = '{6'd56, 3'd0, 1'b1, 10'd5, 9'd320, 9'd199, 6'd56, 14'd11144,
                     6'd48, 15'd18725};
         default: m = '{6'd54, 3'd6, 1'b0, 10'd69, 9'd416, 9'd273, 6'd48, 14'd13104,
                        6'd48, 15'd19419};
      endcase
      return m;
   endfunction

   // Byte length of the packed palette stream, rounded down to even.
   function automatic logic [14:0] packed_bytes(input logic [1:0] md,
                                                input logic [1:0] wsel);
      logic [14:0] p;
      case ({md, wsel})
         4'b00_00: p = 15'd11642;
         4'b00_01: p = 15'd15522;
         4'b00_10: p = 15'd19404;
         4'b01_00: p = 15'd10300;
         4'b01_01: p = 15'd13732;
         4'b01_10: p = 15'd17164;
         4'b10_00: p = 15'd12090;
         4'b10_01: p = 15'd16120;
         4'b10_10: p = 15'd20150;
         4'b11_00: p = 15'd14742;
         4'b11_01: p = 15'd19656;
         4'b11_10: p = 15'd24570;
         default:  p = 15'd0;
      endcase
      return p;
   endfunction

   function automatic logic [6:0] change_step(input logic [1:0] md, input logic [5:0] ci);
      logic [6:0] s;
      if (md == 2'd1) begin
         s = ci[0] ? 7'd16 : 7'd4;
      end else if (md == 2'd2) begin
         s = 7'd8;
      end else if (ci == 6'd15) begin
         s = (md == 2'd0) ? 7'd88 : 7'd112;
      end else if (ci == 6'd31) begin
         s = 7'd12;
      end else if (ci == 6'd37) begin
         s = 7'd100;
      end else begin
         s = 7'd4;
      end
      return s;
   endfunction

   // wsel 0/1/2 selects 9/12/15 bit colours; result is {red, green, blue}.
   function automatic logic [23:0] expand_colour(input logic [14:0] v,
                                                 input logic [1:0] wsel);
      logic [3:0] r4, g4, b4;
      logic [7:0] r, g, b;
      r4 = {v[10:8], v[11]};
      g4 = {v[6:4], v[7]};
      b4 = {v[2:0], v[3]};
      case (wsel)
         2'd0: begin
            r = {v[8:6], 5'd0};
            g = {v[5:3], 5'd0};
            b = {v[2:0], 5'd0};
         end
         2'd1: begin
            r = {r4, 4'd0};
            g = {g4, 4'd0};
            b = {b4, 4'd0};
         end
         default: begin
            r = {r4, v[14], 3'd0};
            g = {g4, v[13], 3'd0};
            b = {b4, v[12], 3'd0};
         end
      endcase
      return {r, g, b};
   endfunction

endpackage

`default_nettype wire

// File: hdl/rppd_ram.sv
// ----------------------------------------------------------------------------
// rppd_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rppd_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16384
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// File: hdl/rppd_ctrl.sv
// ----------------------------------------------------------------------------
// rppd_ctrl
// Sequencer: steps the palette unpacking and the per-pixel work of a group.
// ----------------------------------------------------------------------------
`default_nettype none

module rppd_ctrl
   import rppd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire status_type status,
   output cmd_type         cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECIDE = 4'd1;
   localparam logic [3:0] S_MOD1   = 4'd2;
   localparam logic [3:0] S_MOD2   = 4'd3;
   localparam logic [3:0] S_PIX    = 4'd4;
   localparam logic [3:0] S_LDADDR = 4'd5;
   localparam logic [3:0] S_LDRD   = 4'd6;
   localparam logic [3:0] S_LDWR   = 4'd7;
   localparam logic [3:0] S_CHK    = 4'd8;
   localparam logic [3:0] S_CHGRD  = 4'd9;
   localparam logic [3:0] S_CHGWR  = 4'd10;
   localparam logic [3:0] S_OUT    = 4'd11;

   logic [3:0] state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (status.in_palette) begin
               if (status.pal_active) begin
                  cmd.pal_begin = 1'b1;
                  state_in      = S_MOD1;
               end else begin
                  state_in = S_IDLE;
               end
            end else if (status.img_done) begin
               state_in = S_IDLE;
            end else begin
               cmd.img_shift = 1'b1;
               if (status.group_end) begin
                  cmd.pix_init = 1'b1;
                  state_in     = S_PIX;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_MOD1: begin
            cmd.mod_q = 1'b1;
            state_in  = S_MOD2;
         end
         S_MOD2: begin
            if (status.pal_take) begin
               cmd.pal_entry = 1'b1;
               state_in      = status.pal_last ? S_IDLE : S_MOD1;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_PIX: begin
            state_in = status.col_zero ? S_LDADDR : S_CHK;
         end
         S_LDADDR: begin
            cmd.ld_addr = 1'b1;
            state_in    = S_LDRD;
         end
         S_LDRD: begin
            state_in = S_LDWR;
         end
         S_LDWR: begin
            cmd.ld_write = 1'b1;
            state_in     = status.ld_last ? S_CHK : S_LDRD;
         end
         S_CHK: begin
            state_in = status.chg_hit ? S_CHGRD : S_OUT;
         end
         S_CHGRD: begin
            state_in = S_CHGWR;
         end
         S_CHGWR: begin
            cmd.chg_write = 1'b1;
            state_in      = S_OUT;
         end
         S_OUT: begin
            if (!status.out_busy) begin
               cmd.pix_out = 1'b1;
               state_in    = status.pix_stop ? S_IDLE : S_PIX;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/rppd_datapath.sv
// ----------------------------------------------------------------------------
// rppd_datapath
// Counters, bit buffer, working palette, palette store and pixel register.
// ----------------------------------------------------------------------------
`default_nettype none

module rppd_datapath
   import rppd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic [1:0] mode_select,
   input  wire logic       ste_bit,
   input  wire logic       extra_bit,
   input  wire logic [7:0] byte_value,
   input  wire logic       frame_start,
   input  wire cmd_type    cmd,
   output status_type      status,
   input  wire logic       rsp_tready,
   output logic            rsp_tvalid,
   output logic [23:0]     rsp_tdata,
   output logic            rsp_tuser,
   output logic            rsp_tlast
);

   mode_type    m;
   logic [1:0]  wsel;
   logic [4:0]  w;
   logic [14:0] pkd;

   logic [7:0]        byte_ff, byte_in;
   logic [16:0]       bcnt_ff, bcnt_in;
   logic [16:0]       now_ff, now_in;
   logic [23:0]       buf_ff, buf_in;
   logic [4:0]        bits_ff, bits_in;
   logic [ADDR_W-1:0] sp_ff, sp_in;
   logic [Q_W-1:0]    q_ff, q_in;
   logic [63:0]       pg_ff, pg_in;
   logic [8:0]        col_ff, col_in;
   logic [8:0]        row_ff, row_in;
   logic [9:0]        nchg_ff, nchg_in;
   logic [5:0]        ci_ff, ci_in;
   logic [3:0]        n_ff, n_in;
   logic [3:0]        j_ff, j_in;
   logic [23:0]       wp_ff [16];
   logic [23:0]       wp_in [16];
   logic              ov_ff, ov_in;
   logic [23:0]       orgb_ff, orgb_in;
   logic              olg_ff, olg_in;
   logic              olf_ff, olf_in;

   logic [ADDR_W+RECIP_W-1:0] qprod;
   logic [ADDR_W-1:0]         qn;
   logic [ADDR_W-1:0]         pos;
   logic                      is_border;
   logic                      has_bits;
   logic [4:0]                bits_left;
   logic [23:0]               shifted;
   logic [23:0]               colour;
   logic [ADDR_W:0]           sp_next;
   logic [14:0]               line_base;
   logic [3:0]                idx;
   logic [3:0]                sh;
   logic [8:0]                col_next;
   logic                      wrap;
   logic [8:0]                row_next;
   logic                      ram_we;
   logic [23:0]               ram_wdata;
   logic [23:0]               ram_rdata;
   logic [16:0]               img_off;

   always_comb begin
      m    = mode_info(mode_select);
      wsel = {1'b0, ste_bit} + {1'b0, extra_bit};
      w    = 5'd9 + {1'b0, wsel, 2'b00} - {3'd0, wsel};
      pkd  = packed_bytes(mode_select, wsel);
   end

   // Line position of the store pointer by reciprocal multiplication.
   assign qprod     = sp_ff * m.recip;
   assign qn        = ADDR_W'(q_ff * m.ncol);
   assign pos       = sp_ff - qn;
   assign is_border = m.border && (pos == '0 || pos == ADDR_W'(m.edge_pos));
   assign has_bits  = bits_ff >= w;
   assign bits_left = bits_ff - w;
   assign shifted   = buf_ff >> bits_left;
   assign colour    = expand_colour(shifted[14:0], wsel);
   assign sp_next   = {1'b0, sp_ff} + 1'b1;
   assign line_base = row_ff * m.stride;
   assign img_off   = now_ff - {2'd0, pkd};

   // plane 0 sits in the top word and gives the lowest index bit
   assign sh  = 4'd15 - n_ff;
   assign idx = {pg_ff[{2'd0, sh}], pg_ff[6'd16 + {2'd0, sh}],
                 pg_ff[6'd32 + {2'd0, sh}], pg_ff[6'd48 + {2'd0, sh}]};
   assign col_next = col_ff + 1'b1;
   assign wrap     = col_next >= m.wid;
   assign row_next = wrap ? row_ff + 1'b1 : row_ff;

   always_comb begin
      status.in_palette = now_ff < {2'd0, pkd};
      status.pal_active = {1'b0, sp_ff} < (ADDR_W + 1)'(m.psize);
      status.img_done   = row_ff >= m.hgt;
      status.group_end  = img_off[2:0] == 3'd7;
      status.pal_take   = is_border || has_bits;
      status.pal_last   = sp_next >= (ADDR_W + 1)'(m.psize);
      status.col_zero   = col_ff == '0;
      status.chg_hit    = {1'b0, col_ff} == nchg_ff;
      status.ld_last    = j_ff == 4'd15;
      status.out_busy   = ov_ff && !rsp_tready;
      status.pix_stop   = n_ff == 4'd15 || row_next >= m.hgt;
   end

   always_comb begin
      byte_in = byte_ff;
      bcnt_in = bcnt_ff;
      now_in  = now_ff;
      buf_in  = buf_ff;
      bits_in = bits_ff;
      sp_in   = sp_ff;
      q_in    = q_ff;
      pg_in   = pg_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      nchg_in = nchg_ff;
      ci_in   = ci_ff;
      n_in    = n_ff;
      j_in    = j_ff;
      wp_in   = wp_ff;
      ov_in   = ov_ff && !rsp_tready;
      orgb_in = orgb_ff;
      olg_in  = olg_ff;
      olf_in  = olf_ff;
      ram_we    = 1'b0;
      ram_wdata = colour;

      if (cmd.accept) begin
         byte_in = byte_value;
         if (frame_start) begin
            for (int k = 0; k < 16; k++) begin
               wp_in[k] = '0;
            end
            buf_in  = '0;
            bits_in = '0;
            sp_in   = '0;
            pg_in   = '0;
            col_in  = '0;
            row_in  = '0;
            ci_in   = '0;
            nchg_in = m.start;
            now_in  = '0;
            bcnt_in = 17'd1;
         end else begin
            now_in = bcnt_ff;
            if (bcnt_ff != '1) begin
               bcnt_in = bcnt_ff + 1'b1;
            end
         end
      end

      if (cmd.pal_begin) begin
         buf_in  = {buf_ff[15:0], byte_ff};
         bits_in = bits_ff + 5'd8;
      end

      if (cmd.mod_q) begin
         q_in = qprod[ADDR_W+RECIP_W-1:RECIP_SHIFT];
      end

      if (cmd.pal_entry) begin
         ram_we = 1'b1;
         if (is_border) begin
            ram_wdata = '0;
         end else begin
            bits_in = bits_left;
         end
         sp_in = sp_next[ADDR_W-1:0];
         if (sp_next >= (ADDR_W + 1)'(m.psize)) begin
            bits_in = '0;
         end
      end

      if (cmd.img_shift) begin
         pg_in = {pg_ff[55:0], byte_ff};
      end

      if (cmd.pix_init) begin
         n_in = '0;
      end

      if (cmd.ld_addr) begin
         sp_in   = line_base[ADDR_W-1:0];
         j_in    = {1'b0, m.nfix};
         nchg_in = m.start;
         ci_in   = '0;
      end

      if (cmd.ld_write) begin
         wp_in[j_ff] = ram_rdata;
         sp_in       = sp_next[ADDR_W-1:0];
         j_in        = j_ff + 1'b1;
      end

      if (cmd.chg_write) begin
         wp_in[ci_ff[3:0]] = ram_rdata;
         sp_in   = sp_next[ADDR_W-1:0];
         nchg_in = nchg_ff + {3'd0, change_step(mode_select, ci_ff)};
         ci_in   = ci_ff + 1'b1;
      end

      if (cmd.pix_out) begin
         ov_in   = 1'b1;
         orgb_in = wp_ff[idx];
         olg_in  = n_ff == 4'd15;
         olf_in  = wrap && row_next >= m.hgt;
         col_in  = wrap ? '0 : col_next;
         row_in  = row_next;
         n_in    = n_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bcnt_ff <= '0;
         now_ff  <= '0;
         buf_ff  <= '0;
         bits_ff <= '0;
         sp_ff   <= '0;
         pg_ff   <= '0;
         col_ff  <= '0;
         row_ff  <= '0;
         nchg_ff <= 10'd33;
         ci_ff   <= '0;
         n_ff    <= '0;
         j_ff    <= '0;
         ov_ff   <= 1'b0;
         for (int k = 0; k < 16; k++) begin
            wp_ff[k] <= '0;
         end
      end else begin
         bcnt_ff <= bcnt_in;
         now_ff  <= now_in;
         buf_ff  <= buf_in;
         bits_ff <= bits_in;
         sp_ff   <= sp_in;
         pg_ff   <= pg_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
         nchg_ff <= nchg_in;
         ci_ff   <= ci_in;
         n_ff    <= n_in;
         j_ff    <= j_in;
         ov_ff   <= ov_in;
         wp_ff   <= wp_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      q_ff    <= q_in;
      orgb_ff <= orgb_in;
      olg_ff  <= olg_in;
      olf_ff  <= olf_in;
   end

   rppd_ram #(
      .WIDTH (24),
      .DEPTH (PALETTE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (sp_ff),
      .wr_data (ram_wdata),
      .rd_addr (sp_ff),
      .rd_data (ram_rdata)
   );

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = {orgb_ff[7:0], orgb_ff[15:8], orgb_ff[23:16]};
   assign rsp_tuser  = olg_ff;
   assign rsp_tlast  = olf_ff;

`ifndef SYNTHESIS
   a_pix_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.pix_out |=> ov_ff)
      else $error("pixel word not presented");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.pix_out |-> !(ov_ff && !rsp_tready))
      else $error("pending pixel word overwritten");
   a_load_fixed: assert property (@(posedge clock) disable iff (reset)
      cmd.ld_write |-> j_ff >= {1'b0, m.nfix})
      else $error("fixed palette entry loaded at line start");
   a_bits_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.pal_begin |=> bits_ff <= 5'd23)
      else $error("bit buffer overflow");
`endif

endmodule

`default_nettype wire

// File: hdl/raster_palette_planar_decoder.sv
// A palette byte is accepted and decided, then each colour entry it completes takes
// a quotient step and a store write; once the store is full the byte is only decided.
// An image byte is accepted and decided; the eighth byte of a group then yields up to
// 16 pixels (fewer at frame end) through pixel, change check and output, which waits
// on a pending word, plus a change read mid-line and a palette reload at a line start.
// Reset (synchronous, active high) clears counters and working palette; no store sweep.
// ----------------------------------------------------------------------------
// raster_palette_planar_decoder
// Byte-stream decoder of bit-packed line palettes and four-plane pixel data.
// ----------------------------------------------------------------------------
`default_nettype none

module raster_palette_planar_decoder
   import rppd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] byte_value
   input  wire logic        req_tuser,   // [0] frame_start
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [7:0] red, [15:8] green, [23:16] blue
   output logic             rsp_tuser,   // [0] last_of_group
   output logic             rsp_tlast,   // last_of_frame
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_addr,
   input  wire logic [1:0]  csr_data
);

   logic [1:0] mode_ff;
   logic       ste_ff;
   logic       extra_ff;
   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= '0;
         ste_ff   <= 1'b0;
         extra_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_addr)
            CSR_MODE_SELECT: mode_ff  <= csr_data;
            CSR_STE_BIT:     ste_ff   <= csr_data[0];
            CSR_EXTRA_BIT:   extra_ff <= csr_data[0];
            default:         mode_ff  <= mode_ff;
         endcase
      end
   end

   rppd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rppd_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .mode_select (mode_ff),
      .ste_bit     (ste_ff),
      .extra_bit   (extra_ff),
      .byte_value  (req_tdata),
      .frame_start (req_tuser),
      .cmd         (cmd),
      .status      (status),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Byte-stream test of the planar palette decoder: feeds whole palette
// streams and image groups under several mode and colour-width settings,
// predicts each pixel in the bench and checks the pixel stream in order.
// ----------------------------------------------------------------------------

module tb_top;
   import rppd_pkg::*;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       grp_end;
      logic       frame_end;
   } pixel_t;

   typedef struct {
      logic [7:0]  val;
      logic        sof;
      int          reps;      // 0: rest of the palette stream
      logic        known;
      logic [23:0] rgb;
   } stim_row_t;

   localparam int STORE_DEPTH = 16384;
   localparam int WATCH_LIMIT = 20000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [7:0]  req_tdata = 0;
   logic        req_tuser = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [1:0]  csr_addr = 0;
   logic [1:0]  csr_data = 0;

   raster_palette_planar_decoder dut (.*);

   always #5 clock = ~clock;

   // bench copy of the configuration and decoder state
   logic [1:0]  cfg_mode;
   logic        cfg_ste, cfg_extra;
   logic [23:0] colour_store [STORE_DEPTH];
   logic [23:0] live_pal [16];
   logic [23:0] bit_buf;
   int unsigned bit_cnt, byte_cnt, store_ptr, col, row, next_chg, chg_idx;
   logic [63:0] planes;

   const int unsigned m_ncol   [4] = '{54, 48, 56, 54};
   const int unsigned m_nfix   [4] = '{0, 0, 0, 6};
   const int unsigned m_border [4] = '{1, 1, 1, 0};
   const int unsigned m_start  [4] = '{33, 9, 5, 69};
   const int unsigned m_wid    [4] = '{320, 320, 320, 416};
   const int unsigned m_hgt    [4] = '{199, 199, 199, 273};

   pixel_t      pixel_q [$];
   int unsigned pix_pushed = 0;
   int          errors = 0;
   int          snd_idle = 0, rcv_idle = 0;
   bit          hold_rsp = 0;
   int          idle_cycles = 0;

   function automatic int unsigned colour_bits();
      return 3 * (3 + cfg_ste + cfg_extra);
   endfunction

   function automatic int unsigned palette_len();
      int unsigned ent;
      ent = (m_ncol[cfg_mode] - m_nfix[cfg_mode] - 2 * m_border[cfg_mode]) * m_hgt[cfg_mode];
      return ((colour_bits() * ent + 15) / 8) & ~32'd1;
   endfunction

   function automatic int unsigned chg_gap(input int unsigned md, input int unsigned ci);
      if (md == 1) return (ci & 1) ? 16 : 4;
      if (md == 2) return 8;
      if (ci == 15) return (md == 0) ? 88 : 112;
      if (ci == 31) return 12;
      if (ci == 37) return 100;
      return 4;
   endfunction

   function automatic logic [23:0] widen(input int unsigned v, input int unsigned w);
      int unsigned r, g, b, sh;
      if (w == 9) begin
         r = (v >> 6) & 7; g = (v >> 3) & 7; b = v & 7; sh = 5;
      end else begin
         r = ((v >> 7) & 'he) | ((v >> 11) & 1);
         g = ((v >> 3) & 'he) | ((v >> 7) & 1);
         b = ((v << 1) & 'he) | ((v >> 3) & 1);
         sh = 4;
         if (w == 15) begin
            r = (r << 1) | ((v >> 14) & 1);
            g = (g << 1) | ((v >> 13) & 1);
            b = (b << 1) | ((v >> 12) & 1);
            sh = 3;
         end
      end
      return {8'(r << sh), 8'(g << sh), 8'(b << sh)};
   endfunction

   task automatic restart_frame();
      foreach (live_pal[i]) live_pal[i] = '0;
      bit_buf = '0; bit_cnt = 0; byte_cnt = 0; store_ptr = 0;
      planes = '0; col = 0; row = 0; chg_idx = 0;
      next_chg = m_start[cfg_mode];
   endtask

   task automatic unpack_palette(input logic [7:0] b);
      int unsigned md, w, psize, edge_pos, pos;
      logic [23:0] val;
      md = cfg_mode;
      w = colour_bits();
      psize = (m_ncol[md] - m_nfix[md]) * m_hgt[md];
      edge_pos = (m_ncol[md] - 1) & ~32'd15;
      if (store_ptr >= psize) return;
      bit_buf = {bit_buf[15:0], b};
      bit_cnt += 8;
      while (store_ptr < psize) begin
         pos = store_ptr % m_ncol[md];
         if (m_border[md] && (pos == 0 || pos == edge_pos)) begin
            val = '0;
         end else if (bit_cnt >= w) begin
            bit_cnt -= w;
            val = widen((bit_buf >> bit_cnt) & ((1 << w) - 1), w);
         end else begin
            break;
         end
         colour_store[store_ptr % STORE_DEPTH] = val;
         store_ptr++;
      end
      if (store_ptr >= psize) bit_cnt = 0;
   endtask

   task automatic emit_group();
      int unsigned md, cols, stride, sh, idx;
      pixel_t p;
      md = cfg_mode;
      cols = (m_wid[md] < MAX_WIDTH) ? m_wid[md] : MAX_WIDTH;
      stride = m_ncol[md] - m_nfix[md];
      for (int n = 0; n < 16; n++) begin
         sh = 15 - n;
         if (col == 0) begin
            store_ptr = (row * stride) % STORE_DEPTH;
            for (int j = m_nfix[md]; j < 16; j++) begin
               live_pal[j] = colour_store[store_ptr];
               store_ptr = (store_ptr + 1) % STORE_DEPTH;
            end
            next_chg = m_start[md];
            chg_idx = 0;
         end
         if (col == next_chg) begin
            live_pal[chg_idx & 15] = colour_store[store_ptr % STORE_DEPTH];
            store_ptr = (store_ptr + 1) % STORE_DEPTH;
            next_chg = (next_chg + chg_gap(md, chg_idx)) & 'h3ff;
            chg_idx = (chg_idx + 1) & 63;
         end
         idx = planes[48 + sh] | (planes[32 + sh] << 1) | (planes[16 + sh] << 2)
               | (planes[sh] << 3);
         {p.red, p.green, p.blue} = live_pal[idx];
         p.frame_end = 0;
         col++;
         if (col >= cols) begin
            col = 0;
            row++;
            if (row >= m_hgt[md]) p.frame_end = 1;
         end
         p.grp_end = (n == 15);
         pixel_q.push_back(p);
         pix_pushed++;
         if (row >= m_hgt[md]) break;
      end
   endtask

   task automatic decode_byte(input logic [7:0] b, input logic sof);
      int unsigned now, plen;
      plen = palette_len();
      if (sof) restart_frame();
      now = byte_cnt;
      if (byte_cnt < 'h1ffff) byte_cnt++;
      if (now < plen) begin
         unpack_palette(b);
      end else if (row < m_hgt[cfg_mode]) begin
         planes = {planes[55:0], b};
         if (((now - plen) & 7) == 7) emit_group();
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input logic sof);
      while ($urandom_range(99) < snd_idle) begin
         req_tvalid = 0;
         @(negedge clock);
      end
      req_tvalid = 1;
      req_tdata = b;
      req_tuser = sof;
      do @(posedge clock); while (!req_tready);
      decode_byte(b, sof);
      @(negedge clock);
   endtask

   task automatic drain(input int settle);
      req_tvalid = 0;
      while (pixel_q.size() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [1:0] val);
      csr_valid = 1;
      csr_addr = idx;
      csr_data = val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_MODE_SELECT: cfg_mode = val;
         CSR_STE_BIT:     cfg_ste = val[0];
         default:         cfg_extra = val[0];
      endcase
      @(negedge clock);
      csr_valid = 0;
   endtask

   task automatic set_mode(input logic [1:0] md, input logic ste, input logic ext);
      drain(200);
      write_reg(CSR_MODE_SELECT, md);
      write_reg(CSR_STE_BIT, {1'b0, ste});
      write_reg(CSR_EXTRA_BIT, {1'b0, ext});
   endtask

   // one well-formed picture: full palette stream, then some image groups
   task automatic picture(input int groups, input bit squeeze, input bit pause);
      int unsigned plen, kind;
      plen = palette_len();
      for (int i = 0; i < plen; i++) send_byte(8'($urandom_range(255)), i == 0);
      for (int g = 0; g < groups; g++) begin
         if (squeeze && g == 2) hold_rsp = 1;
         if (pause && g == groups / 2) drain(0);
         kind = $urandom_range(9);
         for (int k = 0; k < 8; k++)
            send_byte(kind == 0 ? 8'h00 : kind == 1 ? 8'hff : 8'($urandom), 0);
      end
   endtask

   stim_row_t directed [] = '{
      '{8'hff, 1, 1, 0, 24'h0},
      '{8'hff, 0, 0, 0, 24'h0},
      '{8'h00, 0, 8, 1, 24'h000000},   // index 0 is a border entry
      '{8'hff, 0, 8, 1, 24'he0e0e0},   // index 15, all-ones 9-bit colour
      '{8'ha5, 0, 8, 0, 24'h0},
      '{8'h5a, 0, 8, 0, 24'h0},
      '{8'h0f, 0, 8, 0, 24'h0},
      '{8'hf0, 0, 8, 0, 24'h0}
   };

   // receiver side: random stalls, one long hold when asked
   initial begin
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_tready = 0;
            repeat (400) @(negedge clock);
            hold_rsp = 0;
         end
         rsp_tready = ($urandom_range(99) >= rcv_idle);
      end
   end

   always @(posedge clock) begin : check_pixel
      pixel_t e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pixel_q.size() == 0) begin
            $error("pixel word with no expectation: %h", rsp_tdata);
            errors++;
         end else begin
            e = pixel_q.pop_front();
            if (rsp_tdata[7:0] !== e.red) begin
               $error("red: expected %h, got %h", e.red, rsp_tdata[7:0]);
               errors++;
            end
            if (rsp_tdata[15:8] !== e.green) begin
               $error("green: expected %h, got %h", e.green, rsp_tdata[15:8]);
               errors++;
            end
            if (rsp_tdata[23:16] !== e.blue) begin
               $error("blue: expected %h, got %h", e.blue, rsp_tdata[23:16]);
               errors++;
            end
            if (rsp_tuser !== e.grp_end) begin
               $error("last_of_group: expected %b, got %b", e.grp_end, rsp_tuser);
               errors++;
            end
            if (rsp_tlast !== e.frame_end) begin
               $error("last_of_frame: expected %b, got %b", e.frame_end, rsp_tlast);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin : stimulus
      int unsigned base, reps;
      cfg_mode = 0; cfg_ste = 0; cfg_extra = 0;
      foreach (colour_store[i]) colour_store[i] = '0;
      restart_frame();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;

      snd_idle = 23; rcv_idle = 50;
      foreach (directed[r]) begin
         reps = (directed[r].reps == 0) ? palette_len() - 1 : directed[r].reps;
         base = pix_pushed;
         for (int i = 0; i < reps; i++) send_byte(directed[r].val, directed[r].sof);
         // the row's pixels are the newest entries at the tail of the queue
         if (directed[r].known)
            for (int i = pixel_q.size() - int'(pix_pushed - base); i < pixel_q.size(); i++)
               {pixel_q[i].red, pixel_q[i].green, pixel_q[i].blue} = directed[r].rgb;
      end

      set_mode(1, 1, 0);
      picture(15, 0, 0);
      set_mode(2, 1, 1);
      picture(15, 1, 0);
      // broken stream: restart in the middle of the palette
      for (int i = 0; i < 150; i++) send_byte(8'($urandom_range(255)), i == 0);
      picture(6, 0, 0);

      snd_idle = 50; rcv_idle = 23;
      set_mode(3, 0, 1);
      picture(30, 0, 1);
      set_mode(0, 0, 0);
      picture(12, 0, 1);

      snd_idle = 0; rcv_idle = 0;
      set_mode(1, 0, 0);
      picture(3980, 0, 0);
      for (int i = 0; i < 16; i++) send_byte(8'($urandom_range(255)), 0);

      drain(200);
      if (errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
